>>> design/ppmfd_pkg.sv
// Package for the PPM frame decoder: shared constants, register indexes
// and the result word layout. No dependencies.

package ppmfd_pkg;

   // Fixed field widths.
   localparam int ChanW        = 7;
   localparam int PackedChans  = 8;
   localparam int PackedW      = ChanW * PackedChans;
   localparam int TimeW        = 32;
   localparam int SlotW        = 5;
   localparam int CountW       = 4;
   localparam int SyncGapW     = 16;
   localparam int MarginW      = 10;
   localparam int CsrDataW     = 64;
   localparam int CsrAddrW     = 5;

   // Default parameter values.
   localparam int MaxChannelsDefault = 8;
   localparam int MinPulseDefault    = 1000;
   localparam int MaxPulseDefault    = 2000;

   // Register reset values.
   localparam logic [CountW-1:0]   ChanCountReset = 4'd8;
   localparam logic [PackedW-1:0]  DefaultsReset  = 56'd28369131510995250;
   localparam logic [SyncGapW-1:0] SyncGapReset   = 16'd5000;
   localparam logic [MarginW-1:0]  MarginReset    = 10'd200;
   localparam logic [ChanW-1:0]    StoreReset     = 7'd50;

   // Edges without sync tolerated before an error is raised.
   localparam logic [SlotW-1:0]    UnsyncLimit    = 5'd10;

   // Configuration register indexes (byte address / 8).
   typedef enum logic [1:0] {
      CsrChanCount = 2'd0,
      CsrDefaults  = 2'd1,
      CsrSyncGap   = 2'd2,
      CsrMargin    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic               frame_end;
      logic               locked;
      logic               fault;
      logic [PackedW-1:0] channel_values;
   } result_type;

endpackage

>>> design/ppm_frame_decoder_unit.sv
// Top level of the PPM frame decoder: configuration registers, decode state
// and per-edge update. Depends on ppmfd_pkg, ppmfd_pulse_scale and
// ppmfd_out_buffer.
//
//   Channel   Direction  Contents
//   req_*     in         tdata[31:0] edge_time
//   rsp_*     out        tdata[55:0] channel_values, tuser[0] fault,
//                        tuser[1] locked, tlast frame_end
//   csr_*     in/out     APB-style, 64-bit data, register i at byte 8*i
//
// Each edge word is handled at the edge that accepts it: the decode state
// and the channel store are updated there, and the result enters a
// two-entry output buffer at that same edge. A new word can be accepted
// every cycle while the buffer has room. With an empty buffer the result is
// on rsp_* in the cycle right after its word was accepted; it waits longer
// only behind earlier results that have not been taken. Reset is synchronous
// and active high; it restores the register reset values, clears the state
// and loads 50 into every channel.
// req_tready drops only when both buffer entries hold results not yet taken.

module ppm_frame_decoder_unit
   import ppmfd_pkg::*;
#(
   parameter int MAX_CHANNELS = MaxChannelsDefault,
   parameter int MIN_PULSE    = MinPulseDefault,
   parameter int MAX_PULSE    = MaxPulseDefault
) (
   input  logic                clock,
   input  logic                reset,
   // Input edges.
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [TimeW-1:0]    req_tdata,   // [31:0] edge_time
   // Results.
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [PackedW-1:0]  rsp_tdata,   // [55:0] channel_values
   output logic [1:0]          rsp_tuser,   // [0] fault, [1] locked
   output logic                rsp_tlast,   // frame_end
   // Configuration port.
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0] csr_prdata,
   output logic                csr_pready
);

   // Only the first eight channels are visible on the result; stored
   // values beyond that never reach an output, so they are not kept.
   localparam int StoreDepth = (MAX_CHANNELS < PackedChans) ? MAX_CHANNELS : PackedChans;
   localparam int IdxW       = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

   // Configuration registers.
   logic [CountW-1:0]   chan_count_ff;
   logic [PackedW-1:0]  defaults_ff;
   logic [SyncGapW-1:0] sync_gap_ff;
   logic [MarginW-1:0]  margin_ff;

   // Decode state.
   logic [TimeW-1:0]    prev_time_ff;
   logic [SlotW-1:0]    slot_ff, slot_in;
   logic                in_sync_ff, in_sync_in;
   logic                error_ff, error_in;
   logic [ChanW-1:0]    store_ff [StoreDepth];
   logic [ChanW-1:0]    store_in [StoreDepth];

   csr_index_type       csr_index;
   logic                csr_write;
   logic                accept;
   logic [TimeW-1:0]    interval;
   logic [ChanW-1:0]    scaled;
   logic                sync_hit;
   logic                slot_ok;
   logic                in_pulse;
   logic                in_safe;
   logic                pulse_ok;
   logic                out_band;
   logic                unsync_err;
   logic                reload;
   logic                store_hit;
   logic [SlotW-1:0]    slot_mid;
   logic [SlotW-1:0]    slot_adv;
   logic                sync_mid;
   logic                frame_end;
   logic                can_push;
   result_type          result;
   result_type          rsp_data;

   // ---------------------------------------------------------------
   // Configuration port. Writes land in the access phase; reads are a
   // plain register mux. The low three address bits are ignored.
   // ---------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[CsrAddrW-1:3]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      case (csr_index)
         CsrChanCount: csr_prdata = CsrDataW'(chan_count_ff);
         CsrDefaults:  csr_prdata = CsrDataW'(defaults_ff);
         CsrSyncGap:   csr_prdata = CsrDataW'(sync_gap_ff);
         CsrMargin:    csr_prdata = CsrDataW'(margin_ff);
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_count_ff <= ChanCountReset;
         defaults_ff   <= DefaultsReset;
         sync_gap_ff   <= SyncGapReset;
         margin_ff     <= MarginReset;
      end else if (csr_write) begin
         case (csr_index)
            CsrChanCount: chan_count_ff <= csr_pwdata[CountW-1:0];
            CsrDefaults:  defaults_ff   <= csr_pwdata[PackedW-1:0];
            CsrSyncGap:   sync_gap_ff   <= csr_pwdata[SyncGapW-1:0];
            CsrMargin:    margin_ff     <= csr_pwdata[MarginW-1:0];
            default:      ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Edge classification. The interval wraps modulo 2^32. A stored time
   // of zero means no edge has been seen yet, so it never counts as a
   // sync gap.
   // ---------------------------------------------------------------
   assign accept   = req_tvalid & req_tready;
   assign interval = req_tdata - prev_time_ff;

   ppmfd_pulse_scale #(
      .MIN_PULSE (MIN_PULSE),
      .MAX_PULSE (MAX_PULSE)
   ) u_scale (
      .interval (interval),
      .value    (scaled)
   );

   always_comb begin
      sync_hit = (prev_time_ff != '0) && (interval > TimeW'(sync_gap_ff));
      slot_ok  = slot_ff <= SlotW'(chan_count_ff);
      in_pulse = (interval > TimeW'(MIN_PULSE)) && (interval < TimeW'(MAX_PULSE));
      // The widened band is checked in 33 bits so that a margin larger than
      // the lower limit simply leaves that side open.
      in_safe  = (({1'b0, interval} + (TimeW + 1)'(margin_ff)) > (TimeW + 1)'(MIN_PULSE))
               && ({1'b0, interval} < ((TimeW + 1)'(MAX_PULSE) + (TimeW + 1)'(margin_ff)));

      pulse_ok   = !sync_hit && in_sync_ff && slot_ok && in_pulse;
      out_band   = !sync_hit && in_sync_ff && slot_ok && !in_pulse && !in_safe;
      unsync_err = !sync_hit && !in_sync_ff && (slot_ff > UnsyncLimit);
      reload     = out_band || unsync_err;
      store_hit  = pulse_ok && (slot_ff < SlotW'(chan_count_ff))
                 && (slot_ff < SlotW'(StoreDepth));
   end

   // ---------------------------------------------------------------
   // Next state. A sync gap parks the slot at all ones so that the common
   // advance brings it to zero. A frame closes once the advanced slot
   // passes the channel count.
   // ---------------------------------------------------------------
   always_comb begin
      slot_mid = slot_ff;
      sync_mid = in_sync_ff;
      error_in = error_ff;
      if (sync_hit) begin
         slot_mid = '1;
         sync_mid = 1'b1;
         error_in = 1'b0;
      end else if (out_band) begin
         slot_mid = '0;
         sync_mid = 1'b0;
         error_in = 1'b1;
      end else if (unsync_err) begin
         slot_mid = '0;
         error_in = 1'b1;
      end

      slot_adv   = slot_mid + SlotW'(1);
      frame_end  = sync_mid && (slot_adv > SlotW'(chan_count_ff));
      slot_in    = frame_end ? '0 : slot_adv;
      in_sync_in = sync_mid && !frame_end;

      for (int i = 0; i < StoreDepth; i++) begin
         store_in[i] = store_ff[i];
         if (reload && (i < int'(chan_count_ff))) begin
            store_in[i] = defaults_ff[ChanW*i +: ChanW];
         end else if (store_hit && (slot_ff[IdxW-1:0] == IdxW'(i))) begin
            store_in[i] = scaled;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff <= '0;
         slot_ff      <= '0;
         in_sync_ff   <= 1'b0;
         error_ff     <= 1'b0;
         for (int i = 0; i < StoreDepth; i++) begin
            store_ff[i] <= StoreReset;
         end
      end else if (accept) begin
         prev_time_ff <= req_tdata;
         slot_ff      <= slot_in;
         in_sync_ff   <= in_sync_in;
         error_ff     <= error_in;
         for (int i = 0; i < StoreDepth; i++) begin
            store_ff[i] <= store_in[i];
         end
      end
   end

   // ---------------------------------------------------------------
   // Result word: the store as it stands after this edge, channel zero in
   // the lowest bits; channels the store does not hold read as zero.
   // ---------------------------------------------------------------
   always_comb begin
      result.channel_values = '0;
      for (int i = 0; i < StoreDepth; i++) begin
         result.channel_values[ChanW*i +: ChanW] = store_in[i];
      end
      result.fault     = error_in;
      result.locked    = in_sync_in;
      result.frame_end = frame_end;
   end

   ppmfd_out_buffer u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .can_push  (can_push),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign req_tready = can_push;
   assign rsp_tdata  = rsp_data.channel_values;
   assign rsp_tuser  = {rsp_data.locked, rsp_data.fault};
   assign rsp_tlast  = rsp_data.frame_end;

   // An error always drops sync, and only a sync gap clears the error.
   a_error_unlocked: assert property (@(posedge clock) disable iff (reset)
      error_ff |-> !in_sync_ff)
      else $error("error flag set while in sync");

   // A sync gap locks the decoder and clears the error flag.
   a_sync_locks: assert property (@(posedge clock) disable iff (reset)
      (accept && sync_hit) |=> (in_sync_ff && !error_ff && slot_ff == '0))
      else $error("sync gap did not start a frame");

   // A closing edge leaves the decoder unlocked at slot zero.
   a_frame_close: assert property (@(posedge clock) disable iff (reset)
      (accept && frame_end) |=> (!in_sync_ff && slot_ff == '0))
      else $error("frame close left sync state behind");

   // A result that closes a frame never reports lock.
   a_close_not_locked: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> !rsp_tuser[1])
      else $error("frame end reported while locked");

endmodule

>>> design/ppmfd_pulse_scale.sv
// Scales an in-band pulse interval to a 0..99 channel value.
// Depends on ppmfd_pkg for widths.

module ppmfd_pulse_scale
   import ppmfd_pkg::*;
#(
   parameter int MIN_PULSE = MinPulseDefault,
   parameter int MAX_PULSE = MaxPulseDefault
) (
   input  logic [TimeW-1:0] interval,
   output logic [ChanW-1:0] value
);

   // The interval lies strictly between the limits, so y = d - MIN is below
   // Range and y*100 fits XW bits. The quotient by Range is a multiply by a
   // rounded-up reciprocal with Shift = XW + ceil(log2 Range), exact for all
   // XW-bit dividends.
   localparam int Range = MAX_PULSE - MIN_PULSE;
   localparam int YW    = $clog2(Range);
   localparam int XW    = $clog2(100 * Range);
   localparam int Shift = XW + $clog2(Range);
   localparam int RW    = XW + 1;
   localparam int PW    = XW + RW;
   localparam logic [63:0] Recip =
      ((64'd1 << Shift) + 64'(Range) - 64'd1) / 64'(Range);

   logic [TimeW-1:0] y_full;
   logic [YW-1:0]    y;
   logic [XW-1:0]    x;
   logic [PW-1:0]    product;

   always_comb begin
      y_full  = interval - TimeW'(MIN_PULSE);
      y       = y_full[YW-1:0];
      // y * 100 as y*64 + y*32 + y*4
      x       = (XW'(y) << 6) + (XW'(y) << 5) + (XW'(y) << 2);
      product = PW'(x) * PW'(Recip[RW-1:0]);
      value   = product[Shift +: ChanW];
   end

endmodule

>>> design/ppmfd_out_buffer.sv
// Two-entry result buffer (output register plus skid register) that lets
// the decoder accept a word while a result waits. Depends on ppmfd_pkg.

module ppmfd_out_buffer
   import ppmfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       can_push,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_data_ff, main_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       pop;

   assign pop       = main_valid_ff & out_ready;
   assign can_push  = ~skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_data_in  = push_data;
         end
      end else if (push) begin
         if (main_valid_ff) begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end else begin
            main_valid_in = 1'b1;
            main_data_in  = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   // The skid entry is only ever filled behind a waiting output entry.
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry valid without output entry");

   // No word is pushed into a full buffer.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("push into full result buffer");

   // A full buffer that is drained keeps its second result.
   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && pop) |=> (main_valid_ff && !skid_valid_ff))
      else $error("skid entry lost on drain");

endmodule
